// ----- hw/rtl/tbpf_pkg.sv -----
`default_nettype none

package tbpf_pkg;

  localparam int VideoBytes    = 16384;
  localparam int ScreenColumns = 160;

  localparam int AddrW    = $clog2(VideoBytes);
  localparam int BankAw   = AddrW - 1;
  localparam int VramWords = VideoBytes / 4;
  localparam int VramAw   = $clog2(VramWords);
  localparam int PalBytes = 64;
  localparam int PalWords = PalBytes / 2;
  localparam int PalAw    = $clog2(PalWords);

  localparam logic [BankAw-1:0] MapLow         = 13'h1800;
  localparam logic [BankAw-1:0] MapHigh        = 13'h1C00;
  localparam logic [BankAw-1:0] SignedDataBase = 13'h0800;
  localparam logic [7:0]        LastVisibleLine = 8'd143;
  localparam logic [7:0]        TileSignFlip    = 8'h80;
  localparam logic [7:0]        WindowXOffset   = 8'd7;

  typedef enum logic [1:0] {
    KindVramWrite = 2'd0,
    KindPalWrite  = 2'd1,
    KindRender    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    CfgLcdControl = 3'd0,
    CfgScrollX    = 3'd1,
    CfgScrollY    = 3'd2,
    CfgWindowX    = 3'd3,
    CfgWindowY    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } vram_wr_t;

  typedef struct packed {
    logic             en;
    logic [PalAw:0]   addr;
    logic [7:0]       data;
  } pal_wr_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tbpf_vram.sv -----
`default_nettype none

// word = {bank1 odd, bank1 even, bank0 odd, bank0 even}
module tbpf_vram (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire tbpf_pkg::vram_wr_t            wr_i,
  input  wire logic [tbpf_pkg::VramAw-1:0]   rd_a_addr_i,
  output logic      [31:0]                   rd_a_data_o,
  input  wire logic [tbpf_pkg::VramAw-1:0]   rd_b_addr_i,
  output logic      [31:0]                   rd_b_data_o
);
  import tbpf_pkg::*;

  logic [31:0] vram_q [VramWords];
  logic [31:0] rd_a_q;
  logic [31:0] rd_b_q;
  logic [4:0]  lane_lsb;

  assign lane_lsb = {wr_i.addr[AddrW-1], wr_i.addr[0], 3'b000};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (wr_i.en) begin
        vram_q[wr_i.addr[VramAw:1]][lane_lsb +: 8] <= wr_i.data;
      end
      rd_a_q <= vram_q[rd_a_addr_i];
      rd_b_q <= vram_q[rd_b_addr_i];
    end
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;

endmodule

`default_nettype wire

// ----- hw/rtl/tbpf_palette.sv -----
`default_nettype none

module tbpf_palette (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire tbpf_pkg::pal_wr_t            wr_i,
  input  wire logic [tbpf_pkg::PalAw-1:0]   rd_addr_i,
  output logic      [15:0]                  rd_data_o
);
  import tbpf_pkg::*;

  logic [15:0] pal_q [PalWords];
  logic [15:0] rd_q;
  logic [3:0]  lane_lsb;

  assign lane_lsb = {wr_i.addr[0], 3'b000};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (wr_i.en) begin
        pal_q[wr_i.addr[PalAw:1]][lane_lsb +: 8] <= wr_i.data;
      end
      rd_q <= pal_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

// ----- hw/rtl/tile_background_pixel_fetch_core.sv -----
// Tile-map background and window pixel fetch.
// Slave stream: one transaction per request. tuser carries the kind
// (video-memory write, palette write, render); tdata carries address,
// write data, line and column. Writes produce no output transaction.
// Master stream: one transaction per render request with the 15-bit
// color split into red/green/blue, the line and column, and the drawn
// flag in tuser. Suppressed pixels (background off, line past 143,
// column off screen) come out with drawn low and a zero color.
// A render passes the stage 1, 2 and 3 registers to the output register.
// Throughput is one transaction per cycle unless the receiver stalls; the
// map/attribute read, tile-row read and palette read each sit in their own
// stage on separate memory ports, so requests follow each other without
// gaps. Video memory writes land in the map-read stage and palette writes
// in the palette-read stage, keeping every access in request order. When
// the receiver stalls the whole pipe holds and s_axis_tready_o drops.
// Reset clears the control registers and the pipe; memory contents stay
// undefined until written. Configuration writes take effect at once; the
// user must write them only while the pipe is empty; the block does not check.
`default_nettype none

module tile_background_pixel_fetch_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // address[13:0], write_data[21:14], line[29:22], column[37:30], zero[39:38]
  input  wire logic [39:0] s_axis_tdata_i,
  // kind[1:0]
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // red[4:0], green[9:5], blue[14:10], out_line[22:15], out_column[30:23], zero[31]
  output logic [31:0]      m_axis_tdata_o,
  // drawn
  output logic             m_axis_tuser_o
);
  import tbpf_pkg::*;

  logic [7:0] lcd_control_q, scroll_x_q, scroll_y_q, window_x_q, window_y_q;

  logic adv;

  logic             s1_valid_q;
  kind_e            s1_kind_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [7:0]       s1_data_q, s1_line_q, s1_col_q;

  logic              use_win, s1_drawn;
  logic [7:0]        x, y;
  logic [BankAw-1:0] map_addr;

  logic             s2_valid_q;
  kind_e            s2_kind_q;
  logic [PalAw:0]   s2_addr_q;
  logic [7:0]       s2_data_q, s2_line_q, s2_col_q;
  logic             s2_drawn_q, s2_odd_q;
  logic [2:0]       s2_x_q, s2_y_q;

  logic [31:0]       map_word, data_word;
  logic [7:0]        tile, attr, tile_n;
  logic [2:0]        row;
  logic [BankAw-1:0] data_addr;

  logic             s3_valid_q;
  kind_e            s3_kind_q;
  logic [PalAw:0]   s3_addr_q;
  logic [7:0]       s3_data_q, s3_line_q, s3_col_q;
  logic             s3_drawn_q, s3_bank_q;
  logic [2:0]       s3_pix_q, s3_pal_q;

  logic [7:0]       lo, hi;
  logic [2:0]       bit_idx;
  logic [1:0]       color;

  logic             out_valid_q, out_drawn_q;
  logic [7:0]       out_line_q, out_col_q;
  logic [15:0]      pal_word, color_word;

  vram_wr_t vram_wr;
  pal_wr_t  pal_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcd_control_q <= '0;
      scroll_x_q    <= '0;
      scroll_y_q    <= '0;
      window_x_q    <= '0;
      window_y_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgLcdControl: lcd_control_q <= cfg_data_i;
        CfgScrollX:    scroll_x_q    <= cfg_data_i;
        CfgScrollY:    scroll_y_q    <= cfg_data_i;
        CfgWindowX:    window_x_q    <= cfg_data_i;
        CfgWindowY:    window_y_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= s_axis_tvalid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q && (s3_kind_q == KindRender);
    end
  end

  // stage 1: address of the map entry
  always_comb begin
    use_win  = lcd_control_q[5] && (window_y_q <= s1_line_q);
    if (use_win) begin
      x        = window_x_q - WindowXOffset + s1_col_q;
      y        = s1_line_q - window_y_q;
      map_addr = (lcd_control_q[6] ? MapHigh : MapLow) + {3'b000, y[7:3], x[7:3]};
    end else begin
      x        = scroll_x_q + s1_col_q;
      y        = s1_line_q + scroll_y_q;
      map_addr = (lcd_control_q[3] ? MapHigh : MapLow) + {3'b000, y[7:3], x[7:3]};
    end
    s1_drawn = lcd_control_q[0] && (s1_line_q <= LastVisibleLine) &&
               ({1'b0, s1_col_q} < 9'(ScreenColumns));
  end

  assign vram_wr.en   = s1_valid_q && (s1_kind_q == KindVramWrite);
  assign vram_wr.addr = s1_addr_q;
  assign vram_wr.data = s1_data_q;

  // stage 2: tile row address
  always_comb begin
    tile      = s2_odd_q ? map_word[15:8] : map_word[7:0];
    attr      = s2_odd_q ? map_word[31:24] : map_word[23:16];
    row       = s2_y_q ^ {3{attr[6]}};
    tile_n    = lcd_control_q[4] ? tile : (tile ^ TileSignFlip);
    data_addr = (lcd_control_q[4] ? '0 : SignedDataBase) + {1'b0, tile_n, row, 1'b0};
  end

  tbpf_vram u_vram (
    .clk_i       (clk_i),
    .en_i        (adv),
    .wr_i        (vram_wr),
    .rd_a_addr_i (map_addr[BankAw-1:1]),
    .rd_a_data_o (map_word),
    .rd_b_addr_i (data_addr[BankAw-1:1]),
    .rd_b_data_o (data_word)
  );

  // stage 3: color index and palette read
  always_comb begin
    lo      = s3_bank_q ? data_word[23:16] : data_word[7:0];
    hi      = s3_bank_q ? data_word[31:24] : data_word[15:8];
    bit_idx = ~s3_pix_q;
    color   = {hi[bit_idx], lo[bit_idx]};
  end

  assign pal_wr.en   = s3_valid_q && (s3_kind_q == KindPalWrite);
  assign pal_wr.addr = s3_addr_q;
  assign pal_wr.data = s3_data_q;

  tbpf_palette u_palette (
    .clk_i     (clk_i),
    .en_i      (adv),
    .wr_i      (pal_wr),
    .rd_addr_i ({s3_pal_q, color}),
    .rd_data_o (pal_word)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_kind_q   <= kind_e'(s_axis_tuser_i);
      s1_addr_q   <= s_axis_tdata_i[13:0];
      s1_data_q   <= s_axis_tdata_i[21:14];
      s1_line_q   <= s_axis_tdata_i[29:22];
      s1_col_q    <= s_axis_tdata_i[37:30];

      s2_kind_q   <= s1_kind_q;
      s2_addr_q   <= s1_addr_q[PalAw:0];
      s2_data_q   <= s1_data_q;
      s2_line_q   <= s1_line_q;
      s2_col_q    <= s1_col_q;
      s2_drawn_q  <= s1_drawn;
      s2_odd_q    <= map_addr[0];
      s2_x_q      <= x[2:0];
      s2_y_q      <= y[2:0];

      s3_kind_q   <= s2_kind_q;
      s3_addr_q   <= s2_addr_q;
      s3_data_q   <= s2_data_q;
      s3_line_q   <= s2_line_q;
      s3_col_q    <= s2_col_q;
      s3_drawn_q  <= s2_drawn_q;
      s3_bank_q   <= attr[3];
      s3_pix_q    <= s2_x_q ^ {3{attr[5]}};
      s3_pal_q    <= attr[2:0];

      out_line_q  <= s3_line_q;
      out_col_q   <= s3_col_q;
      out_drawn_q <= s3_drawn_q;
    end
  end

  assign color_word      = out_drawn_q ? pal_word : '0;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_col_q, out_line_q, color_word[14:0]};
  assign m_axis_tuser_o  = out_drawn_q;

endmodule

`default_nettype wire

// ----- dv/tbpf_checker.sv -----
module tbpf_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [39:0] s_tdata_i,
  input  logic [1:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,
  input  logic        m_tuser_i,
  output int          mismatches_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tbpf_pkg::*;

  localparam logic [13:0] BankStep   = 14'h2000;
  localparam int          MaxPrinted = 100;

  typedef struct packed {
    logic [4:0] red;
    logic [4:0] green;
    logic [4:0] blue;
    logic [7:0] ln;
    logic [7:0] col;
    logic       drawn;
  } pixel_t;

  logic [7:0] vram_q [VideoBytes];
  logic [7:0] pal_q [64];
  logic [7:0] lcd_q, scroll_x_q, scroll_y_q, win_x_q, win_y_q;

  pixel_t pixels_due [$];
  pixel_t want;
  int     mismatches = 0;

  assign mismatches_o = mismatches;

  function automatic pixel_t fetch_pixel(input logic [7:0] ln, input logic [7:0] col);
    logic        win;
    logic [7:0]  x, y, tile, attr, lo, hi;
    logic [13:0] map_addr, data_addr;
    logic [2:0]  cx, ry;
    logic [1:0]  color;
    logic [5:0]  pidx;
    logic [15:0] entry;
    pixel_t      p;
    p = '0;
    p.ln = ln;
    p.col = col;
    p.drawn = lcd_q[0] && (ln <= LastVisibleLine) && ({1'b0, col} < 9'(ScreenColumns));
    if (p.drawn) begin
      win = lcd_q[5] && (win_y_q <= ln);
      if (win) begin
        x = win_x_q - WindowXOffset + col;
        y = ln - win_y_q;
        map_addr = {1'b0, (lcd_q[6] ? MapHigh : MapLow)};
      end else begin
        x = scroll_x_q + col;
        y = ln + scroll_y_q;
        map_addr = {1'b0, (lcd_q[3] ? MapHigh : MapLow)};
      end
      map_addr = map_addr + {4'b0000, y[7:3], x[7:3]};
      tile = vram_q[map_addr];
      attr = vram_q[map_addr + BankStep];
      cx = attr[5] ? ~x[2:0] : x[2:0];
      ry = attr[6] ? ~y[2:0] : y[2:0];
      if (lcd_q[4]) begin
        data_addr = {2'b00, tile, ry, 1'b0};
      end else begin
        data_addr = {1'b0, SignedDataBase} + {2'b00, tile ^ TileSignFlip, ry, 1'b0};
      end
      if (attr[3]) data_addr = data_addr + BankStep;
      lo = vram_q[data_addr];
      hi = vram_q[data_addr + 14'd1];
      color = {hi[3'd7 - cx], lo[3'd7 - cx]};
      pidx = {attr[2:0], color, 1'b0};
      entry = {pal_q[pidx + 6'd1], pal_q[pidx]};
      p.red = entry[4:0];
      p.green = entry[9:5];
      p.blue = entry[14:10];
    end
    return p;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int exp_val);
    if (mismatches < MaxPrinted) begin
      $display("%t mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp_val);
    end
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcd_q = '0;
      scroll_x_q = '0;
      scroll_y_q = '0;
      win_x_q = '0;
      win_y_q = '0;
      pixels_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgLcdControl: lcd_q = cfg_data_i;
          CfgScrollX:    scroll_x_q = cfg_data_i;
          CfgScrollY:    scroll_y_q = cfg_data_i;
          CfgWindowX:    win_x_q = cfg_data_i;
          CfgWindowY:    win_y_q = cfg_data_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        case (s_tuser_i)
          KindVramWrite: vram_q[s_tdata_i[13:0]] = s_tdata_i[21:14];
          KindPalWrite:  pal_q[s_tdata_i[5:0]] = s_tdata_i[21:14];
          KindRender:    pixels_due.push_back(fetch_pixel(s_tdata_i[29:22], s_tdata_i[37:30]));
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        if (pixels_due.size() == 0) begin
          flag_mismatch("pixel with none due", m_tdata_i, 0);
        end else begin
          want = pixels_due.pop_front();
          if (m_tdata_i[4:0] !== want.red) flag_mismatch("red", m_tdata_i[4:0], want.red);
          if (m_tdata_i[9:5] !== want.green) flag_mismatch("green", m_tdata_i[9:5], want.green);
          if (m_tdata_i[14:10] !== want.blue) flag_mismatch("blue", m_tdata_i[14:10], want.blue);
          if (m_tdata_i[22:15] !== want.ln) flag_mismatch("line", m_tdata_i[22:15], want.ln);
          if (m_tdata_i[30:23] !== want.col) flag_mismatch("column", m_tdata_i[30:23], want.col);
          if (m_tuser_i !== want.drawn) flag_mismatch("drawn", m_tuser_i, want.drawn);
        end
      end
      pending_o <= pixels_due.size();
    end
  end

endmodule

// ----- dv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tbpf_pkg::*;

  localparam logic [1:0]  KindUnused  = 2'd3;
  localparam logic [2:0]  CfgUnused   = 3'd7;
  localparam logic [13:0] BankStep    = 14'h2000;
  localparam int          DrainCycles = 8;
  localparam int          QuietLimit  = 4000;
  localparam int          LongHold    = 300;
  localparam int          Phases      = 9;
  localparam int          PhaseItems  = 130;
  localparam int          MidPhase    = 40;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [31:0] m_tdata;
  wire         m_tuser;
  int          mismatches;
  int          pending;

  int tx_idle = 19;
  int rx_idle = 58;
  int hold_reqs = 0;
  int sent = 0;

  // what the stimulus has written so far, so renders only touch written bytes
  logic [7:0] vmem [VideoBytes];
  bit         vset [VideoBytes];
  logic [7:0] lcd_cur = '0;
  logic [7:0] sx_cur = '0;
  logic [7:0] sy_cur = '0;
  logic [7:0] wx_cur = '0;
  logic [7:0] wy_cur = '0;

  tile_background_pixel_fetch_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  tbpf_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .m_tuser_i   (m_tuser),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random backpressure, plus a long hold when requested
  initial begin : receiver
    int served;
    served = 0;
    forever begin
      @(posedge clk);
      if (served != hold_reqs) begin
        served = hold_reqs;
        m_tready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic offer_request(input logic [1:0] kind, input logic [13:0] addr,
                               input logic [7:0] wdata, input logic [7:0] ln,
                               input logic [7:0] col);
    while ($urandom_range(99) < tx_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {2'b00, col, ln, wdata, addr};
    do @(posedge clk); while (!s_tready);
    sent++;
    if (kind == KindVramWrite) begin
      vmem[addr] = wdata;
      vset[addr] = 1'b1;
    end
  endtask

  task automatic ensure_byte(input logic [13:0] addr);
    if (!vset[addr]) begin
      offer_request(KindVramWrite, addr, 8'($urandom), 8'($urandom_range(153)),
                    8'($urandom_range(159)));
    end
  endtask

  task automatic render(input logic [7:0] ln, input logic [7:0] col);
    logic [7:0]  x, y, tile, attr;
    logic [13:0] map_addr, data_addr;
    logic [2:0]  ry;
    if (lcd_cur[0] && (ln <= LastVisibleLine) && ({1'b0, col} < 9'(ScreenColumns))) begin
      if (lcd_cur[5] && (wy_cur <= ln)) begin
        x = wx_cur - WindowXOffset + col;
        y = ln - wy_cur;
        map_addr = {1'b0, (lcd_cur[6] ? MapHigh : MapLow)};
      end else begin
        x = sx_cur + col;
        y = ln + sy_cur;
        map_addr = {1'b0, (lcd_cur[3] ? MapHigh : MapLow)};
      end
      map_addr = map_addr + {4'b0000, y[7:3], x[7:3]};
      ensure_byte(map_addr);
      ensure_byte(map_addr + BankStep);
      tile = vmem[map_addr];
      attr = vmem[map_addr + BankStep];
      ry = attr[6] ? ~y[2:0] : y[2:0];
      if (lcd_cur[4]) begin
        data_addr = {2'b00, tile, ry, 1'b0};
      end else begin
        data_addr = {1'b0, SignedDataBase} + {2'b00, tile ^ TileSignFlip, ry, 1'b0};
      end
      if (attr[3]) data_addr = data_addr + BankStep;
      ensure_byte(data_addr);
      ensure_byte(data_addr + 14'd1);
    end
    offer_request(KindRender, 14'($urandom), 8'($urandom), ln, col);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] lcd, input logic [7:0] sx,
                            input logic [7:0] sy, input logic [7:0] wx,
                            input logic [7:0] wy);
    reg_write(CfgLcdControl, lcd);
    reg_write(CfgScrollX, sx);
    reg_write(CfgScrollY, sy);
    reg_write(CfgWindowX, wx);
    reg_write(CfgWindowY, wy);
    reg_write(CfgUnused, 8'($urandom));
    cfg_we <= 1'b0;
    lcd_cur = lcd;
    sx_cur = sx;
    sy_cur = sy;
    wx_cur = wx;
    wy_cur = wy;
  endtask

  initial begin : stimulus
    int  start;
    int  pick;
    bit  mid_done;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // palette is small enough to fill up front
    for (int a = 0; a < 64; a++) begin
      offer_request(KindPalWrite, {8'($urandom), a[5:0]}, 8'($urandom),
                    8'($urandom_range(153)), 8'($urandom_range(159)));
    end

    // directed: background off, unused kind, edge addresses
    render(8'd0, 8'd0);
    render(8'd153, 8'd159);
    offer_request(KindUnused, 14'h3FFF, 8'hFF, 8'd153, 8'd159);
    offer_request(KindPalWrite, 14'h3FFF, 8'hFF, 8'd0, 8'd0);
    offer_request(KindVramWrite, 14'h3FFF, 8'h00, 8'd0, 8'd0);
    offer_request(KindVramWrite, 14'h0000, 8'hFF, 8'd0, 8'd0);
    drain();
    set_config(8'h01, 8'h00, 8'h00, 8'h00, 8'h00);
    render(8'd0, 8'd0);
    render(8'd143, 8'd159);
    render(8'd144, 8'd0);
    render(8'd153, 8'd159);
    drain();
    set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    render(8'd0, 8'd0);
    render(8'd143, 8'd159);
    drain();
    // window from line 0, x wraps below zero at the left edge
    set_config(8'h79, 8'h00, 8'h00, 8'h00, 8'h00);
    render(8'd0, 8'd0);
    render(8'd100, 8'd7);
    render(8'd143, 8'd159);
    drain();
    set_config(8'h21, 8'h80, 8'h7F, 8'h07, 8'd143);
    render(8'd142, 8'd0);
    render(8'd143, 8'd0);
    render(8'd143, 8'd159);
    drain();

    for (int ph = 0; ph < Phases; ph++) begin
      if (ph < 3) begin
        tx_idle = 19;
        rx_idle = 58;
      end else if (ph < 6) begin
        tx_idle = 58;
        rx_idle = 19;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      case (ph)
        0: set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        1: set_config(8'h79, 8'h00, 8'h00, 8'h00, 8'h00);
        default: set_config(8'($urandom) | 8'($urandom_range(9) != 0), 8'($urandom),
                            8'($urandom), 8'($urandom), 8'($urandom_range(160)));
      endcase
      start = sent;
      mid_done = 1'b0;
      while (sent - start < PhaseItems) begin
        if (!mid_done && (sent - start >= MidPhase)) begin
          mid_done = 1'b1;
          if (ph == 2) hold_reqs++;
          if (ph == 4) drain();
        end
        pick = $urandom_range(99);
        if (pick < 55) begin
          render(8'($urandom_range(153)), 8'($urandom_range(159)));
        end else if (pick < 85) begin
          offer_request(KindVramWrite, 14'($urandom), 8'($urandom),
                        8'($urandom_range(153)), 8'($urandom_range(159)));
        end else if (pick < 97) begin
          offer_request(KindPalWrite, 14'($urandom), 8'($urandom),
                        8'($urandom_range(153)), 8'($urandom_range(159)));
        end else begin
          offer_request(KindUnused, 14'($urandom), 8'($urandom),
                        8'($urandom_range(153)), 8'($urandom_range(159)));
        end
      end
      drain();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/tbpf_pkg.sv
hw/rtl/tbpf_vram.sv
hw/rtl/tbpf_palette.sv
hw/rtl/tile_background_pixel_fetch_core.sv
dv/tbpf_checker.sv
dv/testbench.sv
